// ----- rtl/core/assert_macros.svh -----
// assertion helpers for the console core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/tcbg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tcbg_pkg;

  localparam int unsigned COLUMNS_DEF = 64;
  localparam int unsigned ROWS_DEF = 25;
  localparam int unsigned ADDR_W = 11;

  localparam logic [2:0] REQ_PUT = 3'd0;
  localparam logic [2:0] REQ_GOTO = 3'd1;
  localparam logic [2:0] REQ_CLS = 3'd2;
  localparam logic [2:0] REQ_CLR_EOS = 3'd3;
  localparam logic [2:0] REQ_CLR_EOL = 3'd4;
  localparam logic [2:0] REQ_PIXEL = 3'd5;
  localparam logic [2:0] REQ_READ = 3'd6;
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  localparam logic [1:0] PIX_CLR = 2'd0;
  localparam logic [1:0] PIX_SET = 2'd1;
  localparam logic [1:0] PIX_TEST = 2'd2;
  localparam logic [1:0] PIX_SET_ALT = 2'd3;

  localparam logic [7:0] CH_NL = 8'h0a;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] GFX_FLAG = 8'h80;

  // command kinds handed from the front part to the back part
  typedef enum logic [3:0] {
    OP_NONE,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_CR,
    OP_TAB,
    OP_PRINT,
    OP_GOTO,
    OP_CLS,
    OP_CLR_EOS,
    OP_CLR_EOL,
    OP_PIXEL,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t op;
    logic [7:0] ch;
    logic [7:0] x;
    logic [7:0] y;
    logic [1:0] pix_op;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_ADV,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_FILL,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/tcbg_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tcbg_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [2:0] req_type,
  input  wire logic [7:0] char_code,
  input  wire logic [7:0] x_coord,
  input  wire logic [7:0] y_coord,
  input  wire logic [1:0] pixel_op,
  input  wire logic [tcbg_pkg::ADDR_W-1:0] cell_address,
  output logic cmd_valid,
  output tcbg_pkg::cmd_t cmd,
  input  wire logic cmd_take,
  input  wire logic back_done
);

  // one-entry queue plus an outstanding flag: one item in flight at a time
  tcbg_pkg::cmd_t slot;
  logic full;
  logic pending;
  tcbg_pkg::op_t op_dec;

  always_comb begin
    case (req_type)
      tcbg_pkg::REQ_PUT: begin
        if (char_code == tcbg_pkg::CH_NL) op_dec = tcbg_pkg::OP_NEWLINE;
        else if (char_code == tcbg_pkg::CH_BS) op_dec = tcbg_pkg::OP_BACKSPACE;
        else if (char_code == tcbg_pkg::CH_CR) op_dec = tcbg_pkg::OP_CR;
        else if (char_code == tcbg_pkg::CH_TAB) op_dec = tcbg_pkg::OP_TAB;
        else if (char_code == 8'd0) op_dec = tcbg_pkg::OP_NONE;
        else op_dec = tcbg_pkg::OP_PRINT;
      end
      tcbg_pkg::REQ_GOTO: op_dec = tcbg_pkg::OP_GOTO;
      tcbg_pkg::REQ_CLS: op_dec = tcbg_pkg::OP_CLS;
      tcbg_pkg::REQ_CLR_EOS: op_dec = tcbg_pkg::OP_CLR_EOS;
      tcbg_pkg::REQ_CLR_EOL: op_dec = tcbg_pkg::OP_CLR_EOL;
      tcbg_pkg::REQ_PIXEL: op_dec = tcbg_pkg::OP_PIXEL;
      tcbg_pkg::REQ_READ: op_dec = tcbg_pkg::OP_READ;
      default: op_dec = tcbg_pkg::OP_NONE;
    endcase
  end

  assign busy = pending;
  assign cmd_valid = full;
  assign cmd = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      pending <= 1'b0;
    end else begin
      if (start && !busy) begin
        full <= 1'b1;
        pending <= 1'b1;
      end else if (cmd_take) begin
        full <= 1'b0;
      end
      if (back_done) pending <= 1'b0;
    end
    if (start && !busy) begin
      slot.op <= op_dec;
      slot.ch <= char_code;
      slot.x <= x_coord;
      slot.y <= y_coord;
      slot.pix_op <= pixel_op;
      slot.addr <= cell_address;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tcbg_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tcbg_back #(
  parameter int unsigned COLUMNS = tcbg_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS = tcbg_pkg::ROWS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire tcbg_pkg::cmd_t cmd,
  output logic cmd_take,
  output logic done,
  output logic [7:0] cursor_col,
  output logic [7:0] cursor_row,
  output logic point_lit,
  output logic point_in_range,
  output logic [7:0] cell_value,
  output logic [15:0] scroll_total
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW = $clog2(CELLS);
  localparam logic [7:0] COLS8 = 8'(COLUMNS);
  localparam logic [7:0] ROWS8 = 8'(ROWS);
  localparam logic [AW-1:0] COLS_AW = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_ROW = AW'(COLUMNS * (ROWS - 1));

  logic [7:0] mem [CELLS];
  logic [7:0] rd_data;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  tcbg_pkg::state_t state, state_next;
  tcbg_pkg::cmd_t cur;
  logic [7:0] col, row;
  logic [15:0] scrolls;
  logic [AW-1:0] ptr, lim;
  logic [2:0] tab_left;
  logic [7:0] pmask;
  logic [AW-1:0] pix_off;
  logic lit_r, inr_r;
  logic [7:0] val_r;

  logic on_screen;
  assign on_screen = (col < COLS8) && (row < ROWS8);
  logic [AW-1:0] cur_off;
  assign cur_off = AW'(row) * COLS_AW + AW'(col);

  // pixel address: y/3 by reciprocal, y%3 from it
  logic [7:0] y3;
  logic [1:0] ym3;
  assign y3 = 8'(({8'd0, cur.y} * 16'd171) >> 9);
  assign ym3 = 2'(cur.y - 8'(y3 * 8'd3));
  logic pix_ok;
  assign pix_ok = ({1'b0, cur.x} < 9'(2 * COLUMNS)) && ({2'b0, cur.y} < 10'(3 * ROWS));

  logic addr_ok;
  assign addr_ok = 32'(cur.addr) < CELLS;

  logic is_clr;
  assign is_clr = (cur.op == tcbg_pkg::OP_CLR_EOS) || (cur.op == tcbg_pkg::OP_CLR_EOL);

  logic [7:0] old_g, new_g;
  assign old_g = rd_data[7] ? rd_data : tcbg_pkg::GFX_FLAG;
  assign new_g = cur.pix_op[0] ? (old_g | pmask) : (old_g & ~pmask);

  always_comb begin
    state_next = state;
    case (state)
      tcbg_pkg::ST_CLEAR: if (ptr == LAST_CELL) state_next = tcbg_pkg::ST_IDLE;
      tcbg_pkg::ST_IDLE: if (cmd_valid) state_next = tcbg_pkg::ST_DECODE;
      tcbg_pkg::ST_DECODE: begin
        case (cur.op)
          tcbg_pkg::OP_PRINT, tcbg_pkg::OP_TAB: state_next = tcbg_pkg::ST_WRITE;
          tcbg_pkg::OP_NEWLINE:
            state_next = (row + 8'd1 == ROWS8) ? tcbg_pkg::ST_SCROLL_RD : tcbg_pkg::ST_DONE;
          tcbg_pkg::OP_CLS: state_next = tcbg_pkg::ST_FILL;
          tcbg_pkg::OP_CLR_EOS, tcbg_pkg::OP_CLR_EOL:
            state_next = on_screen ? tcbg_pkg::ST_FILL : tcbg_pkg::ST_DONE;
          tcbg_pkg::OP_PIXEL: state_next = pix_ok ? tcbg_pkg::ST_PIX_RD : tcbg_pkg::ST_DONE;
          tcbg_pkg::OP_READ:
            state_next = addr_ok ? tcbg_pkg::ST_RD_WAIT : tcbg_pkg::ST_DONE;
          default: state_next = tcbg_pkg::ST_DONE;
        endcase
      end
      tcbg_pkg::ST_WRITE: state_next = tcbg_pkg::ST_ADV;
      tcbg_pkg::ST_ADV: begin
        if (col + 8'd1 >= COLS8 && row + 8'd1 >= ROWS8) state_next = tcbg_pkg::ST_SCROLL_RD;
        else if (cur.op == tcbg_pkg::OP_TAB && tab_left != 3'd0) state_next = tcbg_pkg::ST_WRITE;
        else state_next = tcbg_pkg::ST_DONE;
      end
      tcbg_pkg::ST_SCROLL_RD: state_next = tcbg_pkg::ST_SCROLL_WR;
      tcbg_pkg::ST_SCROLL_WR: begin
        if (ptr == LAST_CELL) begin
          if (cur.op == tcbg_pkg::OP_TAB && tab_left != 3'd0) state_next = tcbg_pkg::ST_WRITE;
          else state_next = tcbg_pkg::ST_DONE;
        end else state_next = tcbg_pkg::ST_SCROLL_RD;
      end
      tcbg_pkg::ST_FILL: if (ptr == lim) state_next = tcbg_pkg::ST_DONE;
      tcbg_pkg::ST_PIX_RD: state_next = tcbg_pkg::ST_PIX_WR;
      tcbg_pkg::ST_PIX_WR: state_next = tcbg_pkg::ST_DONE;
      tcbg_pkg::ST_RD_WAIT: state_next = tcbg_pkg::ST_DONE;
      tcbg_pkg::ST_DONE: state_next = tcbg_pkg::ST_IDLE;
      default: state_next = tcbg_pkg::ST_IDLE;
    endcase
  end

  // memory port control, plus the take and done strobes
  always_comb begin
    we = 1'b0;
    waddr = ptr;
    wdata = tcbg_pkg::CH_SPACE;
    raddr = ptr;
    cmd_take = (state == tcbg_pkg::ST_IDLE) && cmd_valid;
    done = (state == tcbg_pkg::ST_DONE);
    case (state)
      tcbg_pkg::ST_CLEAR, tcbg_pkg::ST_FILL: we = 1'b1;
      tcbg_pkg::ST_WRITE: begin
        we = 1'b1;
        waddr = on_screen ? cur_off : '0;
        wdata = (cur.op == tcbg_pkg::OP_TAB) ? tcbg_pkg::CH_SPACE : cur.ch;
      end
      tcbg_pkg::ST_SCROLL_RD: raddr = ptr + COLS_AW;
      tcbg_pkg::ST_SCROLL_WR: begin
        we = 1'b1;
        wdata = (ptr >= LAST_ROW) ? tcbg_pkg::CH_SPACE : rd_data;
      end
      tcbg_pkg::ST_PIX_RD, tcbg_pkg::ST_DECODE: begin
        raddr = (cur.op == tcbg_pkg::OP_READ) ? AW'(cur.addr) : pix_off;
      end
      tcbg_pkg::ST_PIX_WR: begin
        we = (cur.pix_op != tcbg_pkg::PIX_TEST);
        waddr = pix_off;
        wdata = new_g;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcbg_pkg::ST_CLEAR;
      ptr <= '0;
      col <= '0;
      row <= '0;
      scrolls <= '0;
    end else begin
      state <= state_next;
      case (state)
        tcbg_pkg::ST_CLEAR: ptr <= ptr + 1'b1;
        tcbg_pkg::ST_IDLE: if (cmd_valid) cur <= cmd;
        tcbg_pkg::ST_DECODE: begin
          lit_r <= 1'b0;
          inr_r <= (cur.op == tcbg_pkg::OP_PIXEL) && pix_ok;
          val_r <= '0;
          ptr <= is_clr ? cur_off : '0;
          tab_left <= 3'd4 - {1'b0, col[1:0]};
          pix_off <= AW'(y3) * COLS_AW + AW'(cur.x[7:1]);
          pmask <= 8'd1 << ({1'b0, ym3, 1'b0} + {3'd0, cur.x[0]});
          case (cur.op)
            tcbg_pkg::OP_NEWLINE: begin
              col <= '0;
              row <= (row + 8'd1 == ROWS8) ? ROWS8 - 8'd1 : row + 8'd1;
            end
            tcbg_pkg::OP_BACKSPACE: if (col != 8'd0) col <= col - 8'd1;
            tcbg_pkg::OP_CR: col <= '0;
            tcbg_pkg::OP_GOTO: begin
              col <= cur.x;
              row <= cur.y;
            end
            tcbg_pkg::OP_CLS: begin
              col <= '0;
              row <= '0;
              lim <= LAST_CELL;
            end
            tcbg_pkg::OP_CLR_EOS: lim <= LAST_CELL;
            tcbg_pkg::OP_CLR_EOL: lim <= cur_off + AW'(COLS8 - 8'd1 - col);
            default: ;
          endcase
        end
        tcbg_pkg::ST_WRITE: begin
          tab_left <= tab_left - 3'd1;
          if (!on_screen) begin
            col <= '0;
            row <= '0;
          end
        end
        tcbg_pkg::ST_ADV: begin
          ptr <= '0;
          if (col + 8'd1 >= COLS8) begin
            col <= '0;
            if (row + 8'd1 >= ROWS8) row <= ROWS8 - 8'd1;
            else row <= row + 8'd1;
          end else col <= col + 8'd1;
        end
        tcbg_pkg::ST_SCROLL_WR: begin
          ptr <= ptr + 1'b1;
          if (ptr == LAST_CELL) scrolls <= scrolls + 16'd1;
        end
        tcbg_pkg::ST_FILL: ptr <= ptr + 1'b1;
        tcbg_pkg::ST_PIX_WR:
          if (cur.pix_op == tcbg_pkg::PIX_TEST) lit_r <= |(old_g & pmask);
        tcbg_pkg::ST_RD_WAIT: val_r <= rd_data;
        default: ;
      endcase
    end
  end

  assign cursor_col = col;
  assign cursor_row = row;
  assign point_lit = lit_r;
  assign point_in_range = inr_r;
  assign cell_value = val_r;
  assign scroll_total = scrolls;

  `ASSERT_NEXT(a_done_idle, clk, rst, done, state == tcbg_pkg::ST_IDLE, "done not followed by idle")
  `ASSERT_ALWAYS(a_take_idle, clk, rst, !cmd_take || state == tcbg_pkg::ST_IDLE, "take outside idle")
  `ASSERT_ALWAYS(a_lit_range, clk, rst, !done || !point_lit || point_in_range, "lit out of range")

endmodule
`default_nettype wire

// ----- rtl/core/text_console_with_block_graphics_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Text console with cursor and 2x3 block graphics.
// Pulse start with a request on the input ports while busy is low; the
// request is taken at that edge and busy stays high until its result is out.
// The result appears on the output ports for one cycle with done high.
// The receiver cannot stall; every request returns exactly one result.
// A scroll moves every row up by one, cell by cell, and blanks the last row;
// clears write each cleared cell in turn, and each further space of a tab is
// written and advanced like a printed character. One request is in flight at
// a time; the next can be taken the cycle after done.
// After reset the screen is filled with spaces, one cell per cycle; a first
// request is taken during the fill and held in the queue until the fill ends.
// Cursor and scroll count reset to zero.
module text_console_with_block_graphics_top #(
  parameter int unsigned COLUMNS = tcbg_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS = tcbg_pkg::ROWS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [2:0] req_type,
  input  wire logic [7:0] char_code,
  input  wire logic [7:0] x_coord,
  input  wire logic [7:0] y_coord,
  input  wire logic [1:0] pixel_op,
  input  wire logic [tcbg_pkg::ADDR_W-1:0] cell_address,
  output logic done,
  output logic [7:0] cursor_col,
  output logic [7:0] cursor_row,
  output logic point_lit,
  output logic point_in_range,
  output logic [7:0] cell_value,
  output logic [15:0] scroll_total
);

  logic cmd_valid, cmd_take;
  tcbg_pkg::cmd_t cmd;

  tcbg_front u_front (
    .clk, .rst, .start, .busy, .req_type, .char_code, .x_coord, .y_coord,
    .pixel_op, .cell_address, .cmd_valid, .cmd, .cmd_take, .back_done(done)
  );

  tcbg_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take, .done, .cursor_col, .cursor_row,
    .point_lit, .point_in_range, .cell_value, .scroll_total
  );

endmodule
`default_nettype wire

// ----- tb/sv/text_console_with_block_graphics_top_test.sv -----
`timescale 1ns / 1ps
module text_console_with_block_graphics_top_test;

  localparam int COLS = 64;
  localparam int ROWS = 25;
  localparam int CELLS = COLS * ROWS;
  localparam int STALL_LIMIT = 400000;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [7:0] x;
    logic [7:0] y;
    logic [1:0] pop;
    logic [10:0] addr;
  } request_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic lit;
    logic in_rng;
    logic [7:0] val;
    logic [15:0] scrolls;
  } status_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [2:0] req_type = '0;
  logic [7:0] char_code = '0;
  logic [7:0] x_coord = '0;
  logic [7:0] y_coord = '0;
  logic [1:0] pixel_op = '0;
  logic [10:0] cell_address = '0;
  logic busy, done, point_lit, point_in_range;
  logic [7:0] cursor_col, cursor_row, cell_value;
  logic [15:0] scroll_total;

  text_console_with_block_graphics_top dut (.*);

  request_t pending_reqs[$];
  status_t expected_status[$];
  int mismatches = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;
  bit all_sent = 0;

  // console shadow state
  logic [7:0] screen[CELLS];
  logic [7:0] cur_col, cur_row;
  logic [15:0] scroll_cnt;

  initial forever #1 clk = ~clk;

  function automatic void shadow_scroll();
    for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = tcbg_pkg::CH_SPACE;
    scroll_cnt++;
  endfunction

  function automatic void shadow_write(logic [7:0] c);
    if (cur_col >= COLS || cur_row >= ROWS) begin
      cur_col = 0;
      cur_row = 0;
    end
    screen[cur_row * COLS + cur_col] = c;
    cur_col++;
    if (cur_col >= COLS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) begin
      cur_row = ROWS - 1;
      shadow_scroll();
    end
  endfunction

  function automatic status_t console_apply(request_t r);
    status_t s;
    int off, n;
    logic [7:0] old, mask;
    s = '0;
    case (r.kind)
      tcbg_pkg::REQ_PUT: begin
        if (r.ch == tcbg_pkg::CH_NL) begin
          cur_col = 0;
          cur_row++;
          if (cur_row == ROWS) begin
            cur_row = ROWS - 1;
            shadow_scroll();
          end
        end else if (r.ch == tcbg_pkg::CH_BS) begin
          if (cur_col != 0) cur_col--;
        end else if (r.ch == tcbg_pkg::CH_CR) begin
          cur_col = 0;
        end else if (r.ch == tcbg_pkg::CH_TAB) begin
          n = 4 - (cur_col & 3);
          repeat (n) shadow_write(tcbg_pkg::CH_SPACE);
        end else if (r.ch != 0) begin
          shadow_write(r.ch);
        end
      end
      tcbg_pkg::REQ_GOTO: begin
        cur_col = r.x;
        cur_row = r.y;
      end
      tcbg_pkg::REQ_CLS: begin
        foreach (screen[i]) screen[i] = tcbg_pkg::CH_SPACE;
        cur_col = 0;
        cur_row = 0;
      end
      tcbg_pkg::REQ_CLR_EOS, tcbg_pkg::REQ_CLR_EOL: begin
        if (cur_col < COLS && cur_row < ROWS) begin
          off = cur_row * COLS + cur_col;
          n = (r.kind == tcbg_pkg::REQ_CLR_EOS) ? CELLS - off : COLS - cur_col;
          for (int i = 0; i < n; i++) screen[off + i] = tcbg_pkg::CH_SPACE;
        end
      end
      tcbg_pkg::REQ_PIXEL: begin
        if (r.x < 2 * COLS && r.y < 3 * ROWS) begin
          s.in_rng = 1;
          mask = 8'h01 << ((r.y % 3) * 2 + r.x[0]);
          off = (r.y / 3) * COLS + r.x / 2;
          old = screen[off];
          if (!old[7]) old = tcbg_pkg::GFX_FLAG;
          if (r.pop == tcbg_pkg::PIX_TEST) s.lit = |(old & mask);
          else begin
            if (r.pop[0]) old = old | mask;
            else old = old & ~mask;
            screen[off] = old;
          end
        end
      end
      tcbg_pkg::REQ_READ: if (r.addr < CELLS) s.val = screen[r.addr];
      default: ;
    endcase
    s.col = cur_col;
    s.row = cur_row;
    s.scrolls = scroll_cnt;
    return s;
  endfunction

  function automatic request_t random_req();
    request_t r;
    int pick;
    r.kind = $urandom_range(0, 7);
    r.ch = $urandom;
    r.x = $urandom;
    r.y = $urandom;
    r.pop = $urandom;
    r.addr = $urandom;
    pick = $urandom_range(0, 99);
    // bias toward printing, pixels and reads mostly in range; CLS and EOS clears mostly become EOL clears
    if (pick < 35) begin
      r.kind = tcbg_pkg::REQ_PUT;
      case ($urandom_range(0, 5))
        0: r.ch = tcbg_pkg::CH_NL;
        1: r.ch = tcbg_pkg::CH_TAB;
        2: r.ch = ($urandom_range(0, 1)) ? tcbg_pkg::CH_BS : tcbg_pkg::CH_CR;
        default: r.ch = $urandom_range(33, 126);
      endcase
    end else if (pick < 60) begin
      r.kind = tcbg_pkg::REQ_PIXEL;
      r.x = $urandom_range(0, 130);
      r.y = $urandom_range(0, 78);
    end else if (pick < 75) begin
      r.kind = tcbg_pkg::REQ_READ;
      r.addr = $urandom_range(0, CELLS + 10);
    end else if (pick < 85) begin
      r.kind = tcbg_pkg::REQ_GOTO;
      if ($urandom_range(0, 3) != 0) begin
        r.x = $urandom_range(0, COLS);
        r.y = $urandom_range(0, ROWS);
      end
    end else if (r.kind inside {tcbg_pkg::REQ_CLS, tcbg_pkg::REQ_CLR_EOS} &&
                 $urandom_range(0, 3) != 0) begin
      r.kind = tcbg_pkg::REQ_CLR_EOL;
    end
    return r;
  endfunction

  function automatic request_t mk(logic [2:0] k, logic [7:0] c, logic [7:0] x,
                                  logic [7:0] y, logic [1:0] p, logic [10:0] a);
    request_t r;
    r.kind = k; r.ch = c; r.x = x; r.y = y; r.pop = p; r.addr = a;
    return r;
  endfunction

  initial begin
    foreach (screen[i]) screen[i] = tcbg_pkg::CH_SPACE;
    cur_col = 0;
    cur_row = 0;
    scroll_cnt = 0;
    pending_reqs.push_back(mk(tcbg_pkg::REQ_PUT, 8'h41, 0, 0, 0, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_PUT, 8'hff, 0, 0, 0, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_PUT, 8'h00, 0, 0, 0, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_PUT, tcbg_pkg::CH_TAB, 0, 0, 0, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_PUT, tcbg_pkg::CH_BS, 0, 0, 0, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_PUT, tcbg_pkg::CH_CR, 0, 0, 0, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_READ, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_READ, 0, 0, 0, 0, 11'h7ff));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_GOTO, 0, COLS - 1, ROWS - 1, 0, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_PUT, 8'h7e, 0, 0, 0, 0)); // wrap + scroll
    pending_reqs.push_back(mk(tcbg_pkg::REQ_PUT, tcbg_pkg::CH_NL, 0, 0, 0, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_GOTO, 0, 8'hff, 8'hff, 0, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_CLR_EOL, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_CLR_EOS, 0, 0, 0, 0, 0));
    // off-screen row wraps
    pending_reqs.push_back(mk(tcbg_pkg::REQ_PUT, tcbg_pkg::CH_NL, 0, 0, 0, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_PUT, 8'h5a, 0, 0, 0, 0)); // prints at home after the wrap
    pending_reqs.push_back(mk(tcbg_pkg::REQ_PIXEL, 0, 0, 0, tcbg_pkg::PIX_SET, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_PIXEL, 0, 127, 74, tcbg_pkg::PIX_SET_ALT, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_PIXEL, 0, 127, 74, tcbg_pkg::PIX_TEST, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_PIXEL, 0, 127, 74, tcbg_pkg::PIX_CLR, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_PIXEL, 0, 128, 75, tcbg_pkg::PIX_SET, 0));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_READ, 0, 0, 0, 0, CELLS - 1));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_UNUSED, 8'hff, 8'hff, 8'hff,
                              tcbg_pkg::PIX_SET_ALT, 11'h7ff));
    pending_reqs.push_back(mk(tcbg_pkg::REQ_CLS, 0, 0, 0, 0, 0));
    repeat (1030) pending_reqs.push_back(random_req());
    repeat (5) @(posedge clk);
    rst <= 0;
  end

  int sent = 0;
  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
    end else begin
      idle_pct <= (sent < 350) ? 37 : (sent < 700) ? 57 : 0;
      if (start && !busy) sent <= sent + 1;
      // hold start high while the previous beat is still waiting
      if (!(start && busy)) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          request_t r;
          r = pending_reqs.pop_front();
          start <= 1;
          req_type <= r.kind;
          char_code <= r.ch;
          x_coord <= r.x;
          y_coord <= r.y;
          pixel_op <= r.pop;
          cell_address <= r.addr;
          expected_status.push_back(console_apply(r));
        end else begin
          start <= 0;
          if (pending_reqs.size() == 0) all_sent <= 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      quiet_cycles <= (done || (start && !busy)) ? 0 : quiet_cycles + 1;
      if (done) begin
        status_t got, want;
        got = '{cursor_col, cursor_row, point_lit, point_in_range, cell_value,
                scroll_total};
        if (expected_status.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %h", got);
        end else begin
          want = expected_status.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected col %0d row %0d lit %0d rng %0d val %h scr %0d, got col %0d row %0d lit %0d rng %0d val %h scr %0d",
                       want.col, want.row, want.lit, want.in_rng, want.val, want.scrolls,
                       got.col, got.row, got.lit, got.in_rng, got.val, got.scrolls);
          end
        end
      end
    end
  end

  initial begin
    wait (!rst);
    fork
      begin
        wait (all_sent && !start && expected_status.size() == 0);
        repeat (50) @(posedge clk);
      end
      wait (quiet_cycles >= STALL_LIMIT);
    join_any
    if (quiet_cycles >= STALL_LIMIT || expected_status.size() != 0) begin
      $display("SCOREBOARD MISMATCH");
    end else if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- text_console_with_block_graphics_top.f -----
+incdir+rtl/core
rtl/core/tcbg_pkg.sv
rtl/core/tcbg_front.sv
rtl/core/tcbg_back.sv
rtl/core/text_console_with_block_graphics_top.sv
tb/sv/text_console_with_block_graphics_top_test.sv
